/* rtl/core/fql_pkg.sv */
// Shared types and constants for the fault qualify and latch monitor.
package fql_pkg;

    localparam int ACT_W      = 3;
    localparam int VAL_W      = 32;
    localparam int IDX_W      = 6;
    localparam int RUN_W      = 8;
    localparam int CNT_W      = 10;
    localparam int FLAG_W     = 64;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 80;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MASK = 2'd2;

    localparam logic [THR_W-1:0]  SHORT_THR_RST = 8'd1;
    localparam logic [THR_W-1:0]  LONG_THR_RST  = 8'd5;

    localparam logic [ACT_W-1:0] ACT_RANGE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BELOW_MAX = 3'd1;
    localparam logic [ACT_W-1:0] ACT_AT_LEAST  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_EQUAL     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NOT_EQUAL = 3'd4;

    typedef struct packed {
        logic load;
        logic exec;
    } fql_cmd_t;

    typedef struct packed {
        logic [RUN_W-1:0] run;
        logic [CNT_W-1:0] cnt;
    } fql_entry_t;

endpackage

/* rtl/core/fault_qualify_latch_monitor.sv */
// Top level of the fault qualify and latch monitor.
//
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | s_tuser action, s_tdata check operands and slot
// m_*     | out | m_tvalid/m_tready  | m_tdata slot verdict, status word, event total
// cfg_*   | in  | cfg_we             | cfg_index register, cfg_data value
//
// Each beat is accepted (slot memory read), then executed (read-modify-write of
// the slot entry and latch flags); no new beat is accepted until execute is done.
// The result sits in an output register; a new beat is accepted while it waits,
// and execute stalls only while the previous result has not been taken.
// Reset clears the slot entry valid bits and latch flags at once; no clearing pass.
module fault_qualify_latch_monitor
    import fql_pkg::*;
#(
    parameter int NUM_SLOTS   = 64,
    parameter int EVENT_LIMIT = 999
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] sample_value, [63:32] bound_low, [95:64] bound_high, [101:96] error_index
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [2:0] action
    input  logic [ACT_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] error_latched, [1] new_event, [2] cleared, [66:3] status_bits,
    // [76:67] event_total
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fql_cmd_t cmd;

    fql_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fql_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .EVENT_LIMIT (EVENT_LIMIT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/core/fql_ctrl.sv */
// Controller: accept and execute sequencing, output beat valid.
module fql_ctrl
    import fql_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output fql_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == ST_EXEC) && out_free;
    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.exec)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_EXEC) && !s_tready)
        else $error("accepted beat did not move to execute");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && m_valid_reg && !m_tready |=> (state_reg == ST_EXEC))
        else $error("item left execute while output was blocked");

    a_exec_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("executed item did not present an output beat");

endmodule

/* rtl/core/fql_datapath.sv */
// Datapath: config registers, slot memory, check, latch flags, result register.
module fql_datapath
    import fql_pkg::*;
#(
    parameter int NUM_SLOTS   = 64,
    parameter int EVENT_LIMIT = 999
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fql_cmd_t              cmd,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [ACT_W-1:0]      s_tuser,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [THR_W-1:0]  short_thr_reg;
    logic [THR_W-1:0]  long_thr_reg;
    logic [FLAG_W-1:0] long_mask_reg;
    logic [FLAG_W-1:0] latch_reg, latch_next;
    logic [NUM_SLOTS-1:0] ent_valid_reg;

    fql_entry_t mem [NUM_SLOTS];
    fql_entry_t rd_reg;
    logic       rd_valid_reg;

    logic [ACT_W-1:0]        act_reg;
    logic signed [VAL_W-1:0] samp_reg;
    logic signed [VAL_W-1:0] lo_reg;
    logic signed [VAL_W-1:0] hi_reg;
    logic [IDX_W-1:0]        idx_reg;

    logic                    err_latched_reg;
    logic                    new_event_reg;
    logic                    cleared_reg;
    logic [FLAG_W-1:0]       status_reg;
    logic [CNT_W-1:0]        total_reg;

    logic [IDX_W-1:0] idx_in;
    logic [AW-1:0]    addr_in;
    logic [AW-1:0]    addr_reg;
    logic             in_range;
    logic             known;
    logic             normal;
    logic             latched;
    logic [THR_W-1:0] thr;
    logic [RUN_W-1:0] run_cur, run_inc;
    logic [CNT_W-1:0] cnt_cur;
    fql_entry_t       wr_ent;
    logic             wr_en;
    logic             ev;
    logic             clr;

    assign idx_in   = s_tdata[101:96];
    assign addr_in  = AW'(idx_in);
    assign addr_reg = AW'(idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_thr_reg <= SHORT_THR_RST;
            long_thr_reg  <= LONG_THR_RST;
            long_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHORT_THR: short_thr_reg <= cfg_data[THR_W-1:0];
                CFG_LONG_THR:  long_thr_reg  <= cfg_data[THR_W-1:0];
                CFG_LONG_MASK: long_mask_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= s_tuser;
            samp_reg <= s_tdata[31:0];
            lo_reg   <= s_tdata[63:32];
            hi_reg   <= s_tdata[95:64];
            idx_reg  <= idx_in;
            rd_reg   <= mem[addr_in];
        end
        if (wr_en)
        begin
            mem[addr_reg] <= wr_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            latch_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_valid_reg <= ent_valid_reg[addr_in];
            end
            if (wr_en)
            begin
                ent_valid_reg[addr_reg] <= 1'b1;
            end
            if (cmd.exec)
            begin
                latch_reg <= latch_next;
            end
        end
    end

    assign in_range = {1'b0, idx_reg} < (IDX_W+1)'(NUM_SLOTS);
    assign latched  = latch_reg[idx_reg];
    assign thr      = long_mask_reg[idx_reg] ? long_thr_reg : short_thr_reg;
    assign run_cur  = rd_valid_reg ? rd_reg.run : '0;
    assign cnt_cur  = rd_valid_reg ? rd_reg.cnt : '0;
    assign run_inc  = run_cur + RUN_W'(1);

    always_comb
    begin
        known = 1'b1;
        case (act_reg)
            ACT_RANGE:     normal = (lo_reg <= samp_reg) && (samp_reg < hi_reg);
            ACT_BELOW_MAX: normal = samp_reg < hi_reg;
            ACT_AT_LEAST:  normal = samp_reg >= lo_reg;
            ACT_EQUAL:     normal = samp_reg == lo_reg;
            ACT_NOT_EQUAL: normal = samp_reg != lo_reg;
            default:
            begin
                normal = 1'b0;
                known  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        latch_next = latch_reg;
        wr_ent     = '{run: run_cur, cnt: cnt_cur};
        wr_en      = 1'b0;
        ev         = 1'b0;
        clr        = 1'b0;
        if (in_range && known)
        begin
            if (normal)
            begin
                wr_ent.run = '0;
                wr_en      = cmd.exec;
                if (latched)
                begin
                    latch_next[idx_reg] = 1'b0;
                    clr                 = 1'b1;
                end
            end
            else if (!latched)
            begin
                wr_en = cmd.exec;
                if (thr <= run_inc)
                begin
                    wr_ent.run          = '0;
                    latch_next[idx_reg] = 1'b1;
                    ev                  = 1'b1;
                    if (cnt_cur < CNT_W'(EVENT_LIMIT))
                    begin
                        wr_ent.cnt = cnt_cur + CNT_W'(1);
                    end
                end
                else
                begin
                    wr_ent.run = run_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            err_latched_reg <= in_range && latch_next[idx_reg];
            new_event_reg   <= ev;
            cleared_reg     <= clr;
            status_reg      <= latch_next;
            total_reg       <= in_range ? wr_ent.cnt : '0;
        end
    end

    assign m_tdata = {3'b000, total_reg, status_reg, cleared_reg, new_event_reg,
                      err_latched_reg};

    a_no_flag_past_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (latch_reg >> NUM_SLOTS) == '0)
        else $error("latch flag set beyond the slot count");

    a_event_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !(new_event_reg && cleared_reg))
        else $error("one item both latched and cleared its slot");

    a_flag_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> err_latched_reg == status_reg[idx_reg])
        else $error("reported latch disagrees with status word");

endmodule
